// File: src/pixel_color_index_mapper_unit_assert.svh
// Assertion macros for the pixel color index mapper unit.
// Used by the front and back modules; expects clk_i and rst_ni in scope.
`ifndef PIXEL_COLOR_INDEX_MAPPER_UNIT_ASSERT_SVH
`define PIXEL_COLOR_INDEX_MAPPER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PCIM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCIM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pcim_pkg.sv
// Package for the pixel color index mapper unit.
// Holds codes, beat types and scaling tables; no dependencies.
`default_nettype none

package pcim_pkg;

  localparam logic [15:0] CV_MAX     = 16'hFFFF;
  localparam logic [6:0]  LUM_R      = 7'd30;
  localparam logic [6:0]  LUM_G      = 7'd59;
  localparam logic [6:0]  LUM_B      = 7'd11;
  localparam logic [6:0]  LUM_ROUND  = 7'd50;
  localparam logic [23:0] LUM_RECIP  = 24'd10737419;
  localparam int          LUM_SHIFT  = 30;
  localparam logic [11:0] DIV3_MUL   = 12'd43;
  localparam int          DIV3_SHIFT = 7;

  localparam logic CFG_COLOR_MODEL = 1'b0;
  localparam logic CFG_PIXEL_DEPTH = 1'b1;

  typedef enum logic [1:0] {
    MODEL_GRAY,
    MODEL_RGB,
    MODEL_CMYK,
    MODEL_CMYK_MONO
  } model_e;

  typedef enum logic [1:0] {
    REQ_RGB2IDX,
    REQ_CMYK2IDX,
    REQ_IDX2RGB,
    REQ_NONE
  } req_e;

  typedef enum logic [2:0] {
    OP_BAD,
    OP_GRAY_FWD,
    OP_RGB_FWD,
    OP_KMONO_FWD,
    OP_CMYK_FWD,
    OP_GRAY_INV,
    OP_RGB_INV,
    OP_CMYK_INV
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [4:0]  bpc;
    logic [15:0] comp_a;
    logic [15:0] comp_b;
    logic [15:0] comp_c;
    logic [15:0] comp_d;
    logic [31:0] index;
  } cmd_t;

  typedef struct packed {
    logic [31:0] index;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        bad;
  } res_t;

  // Quotient of 65535 by (2^bpc - 1) with the remainder left as 2^r - 1.
  function automatic logic [15:0] scale_quot(input logic [4:0] bpc);
    logic [15:0] q;
    case (bpc)
      5'd1:    q = 16'd65535;
      5'd2:    q = 16'd21845;
      5'd3:    q = 16'd9362;
      5'd4:    q = 16'd4369;
      5'd5:    q = 16'd2114;
      5'd6:    q = 16'd1040;
      5'd7:    q = 16'd516;
      5'd8:    q = 16'd257;
      5'd9:    q = 16'd128;
      5'd10:   q = 16'd64;
      5'd11:   q = 16'd32;
      5'd12:   q = 16'd16;
      5'd13:   q = 16'd8;
      5'd14:   q = 16'd4;
      5'd15:   q = 16'd2;
      5'd16:   q = 16'd1;
      default: q = 16'd0;
    endcase
    return q;
  endfunction

  function automatic logic [2:0] scale_rem_bits(input logic [4:0] bpc);
    logic [2:0] r;
    case (bpc)
      5'd3, 5'd5, 5'd15: r = 3'd1;
      5'd7, 5'd14:       r = 3'd2;
      5'd13:             r = 3'd3;
      5'd6, 5'd12:       r = 3'd4;
      5'd11:             r = 3'd5;
      5'd10:             r = 3'd6;
      5'd9:              r = 3'd7;
      default:           r = 3'd0;
    endcase
    return r;
  endfunction

  // floor(y / mask) for mask = 2^bpc - 1 and y < 2^(2*bpc).
  function automatic logic [15:0] div_mask(input logic [23:0] y, input logic [4:0] bpc,
                                           input logic [15:0] mask);
    logic [23:0] hi;
    logic [16:0] t;
    logic [15:0] q;
    hi = y >> bpc;
    t  = {1'b0, hi[15:0]} + {1'b0, y[15:0] & mask};
    q  = hi[15:0];
    if (t >= {mask, 1'b0}) begin
      q = q + 16'd2;
    end else if (t >= {1'b0, mask}) begin
      q = q + 16'd1;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

// File: src/pcim_front.sv
// Front end of the pixel color index mapper: config registers, request
// classification and the command queue. Depends on pcim_pkg.
`default_nettype none

module pcim_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [5:0]       cfg_data_i,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire logic [1:0]       req_type_i,
  input  wire logic [15:0]      comp_a_i,
  input  wire logic [15:0]      comp_b_i,
  input  wire logic [15:0]      comp_c_i,
  input  wire logic [15:0]      comp_d_i,
  input  wire logic [31:0]      index_in_i,
  output pcim_pkg::cmd_t        cmd_o,
  output logic                  cmd_valid_o,
  input  wire logic             cmd_ready_i
);

  pcim_pkg::model_e color_model_q, color_model_d;
  logic [5:0]       pixel_depth_q, pixel_depth_d;

  pcim_pkg::cmd_t   cmd_mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cmd_cnt_q, cmd_cnt_d;

  pcim_pkg::req_e   req;
  logic             one_comp;
  logic             four_comp;
  logic [11:0]      depth_x43;
  logic [5:0]       bpc_w;
  logic             bad;
  pcim_pkg::op_e    op;
  pcim_pkg::cmd_t   cmd_new;
  logic             in_acc;
  logic             cmd_pop;

  always_comb begin
    color_model_d = color_model_q;
    pixel_depth_d = pixel_depth_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == pcim_pkg::CFG_COLOR_MODEL) begin
        color_model_d = pcim_pkg::model_e'(cfg_data_i[1:0]);
      end else begin
        pixel_depth_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_model_q <= pcim_pkg::MODEL_GRAY;
      pixel_depth_q <= 6'd1;
    end else begin
      color_model_q <= color_model_d;
      pixel_depth_q <= pixel_depth_d;
    end
  end

  // Classify: components per pixel, bits per component, operation.
  always_comb begin
    req = pcim_pkg::req_e'(req_type_i);
    if (req == pcim_pkg::REQ_IDX2RGB) begin
      one_comp  = (color_model_q == pcim_pkg::MODEL_GRAY) ||
                  (color_model_q == pcim_pkg::MODEL_CMYK_MONO);
      four_comp = (color_model_q == pcim_pkg::MODEL_CMYK);
    end else begin
      one_comp  = (color_model_q == pcim_pkg::MODEL_GRAY);
      four_comp = (color_model_q == pcim_pkg::MODEL_CMYK) ||
                  (color_model_q == pcim_pkg::MODEL_CMYK_MONO);
    end
    depth_x43 = 12'(pixel_depth_q) * pcim_pkg::DIV3_MUL;
    if (one_comp) begin
      bpc_w = pixel_depth_q;
    end else if (four_comp) begin
      bpc_w = {2'b00, pixel_depth_q[5:2]};
    end else begin
      bpc_w = {1'b0, depth_x43[pcim_pkg::DIV3_SHIFT +: 5]};
    end
    bad = (pixel_depth_q == 6'd0) || (pixel_depth_q > 6'd32) ||
          (bpc_w == 6'd0) || (bpc_w > 6'd16) || (req == pcim_pkg::REQ_NONE) ||
          ((req == pcim_pkg::REQ_CMYK2IDX) &&
           ((color_model_q == pcim_pkg::MODEL_GRAY) ||
            (color_model_q == pcim_pkg::MODEL_RGB)));
    op = pcim_pkg::OP_BAD;
    if (!bad) begin
      unique case (req)
        pcim_pkg::REQ_RGB2IDX: begin
          if (color_model_q == pcim_pkg::MODEL_GRAY) begin
            op = pcim_pkg::OP_GRAY_FWD;
          end else if (color_model_q == pcim_pkg::MODEL_RGB) begin
            op = pcim_pkg::OP_RGB_FWD;
          end else begin
            op = pcim_pkg::OP_KMONO_FWD;
          end
        end
        pcim_pkg::REQ_CMYK2IDX: op = pcim_pkg::OP_CMYK_FWD;
        pcim_pkg::REQ_IDX2RGB: begin
          if (one_comp) begin
            op = pcim_pkg::OP_GRAY_INV;
          end else if (four_comp) begin
            op = pcim_pkg::OP_CMYK_INV;
          end else begin
            op = pcim_pkg::OP_RGB_INV;
          end
        end
        default: op = pcim_pkg::OP_BAD;
      endcase
    end
    cmd_new.op     = op;
    cmd_new.bpc    = bpc_w[4:0];
    cmd_new.comp_a = comp_a_i;
    cmd_new.comp_b = comp_b_i;
    cmd_new.comp_c = comp_c_i;
    cmd_new.comp_d = comp_d_i;
    cmd_new.index  = index_in_i;
  end

  assign full_o      = (cmd_cnt_q == 2'd2);
  assign in_acc      = push_i && !full_o;
  assign cmd_valid_o = (cmd_cnt_q != 2'd0);
  assign cmd_pop     = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = cmd_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d  = in_acc ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d  = cmd_pop ? !rd_ptr_q : rd_ptr_q;
    cmd_cnt_d = cmd_cnt_q;
    if (in_acc && !cmd_pop) begin
      cmd_cnt_d = cmd_cnt_q + 2'd1;
    end else if (!in_acc && cmd_pop) begin
      cmd_cnt_d = cmd_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= 1'b0;
      rd_ptr_q  <= 1'b0;
      cmd_cnt_q <= 2'd0;
    end else begin
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      cmd_cnt_q <= cmd_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

`include "pixel_color_index_mapper_unit_assert.svh"

`PCIM_ASSERT_NEXT(a_cnt_up, in_acc && !cmd_pop, cmd_cnt_q == $past(cmd_cnt_q) + 2'd1, "cmd count did not grow")
`PCIM_ASSERT_NEXT(a_cnt_down, cmd_pop && !in_acc, cmd_cnt_q == $past(cmd_cnt_q) - 2'd1, "cmd count did not shrink")
`PCIM_ASSERT_NEXT(a_cmd_seen, in_acc && (cmd_cnt_q == 2'd0), cmd_valid_o, "accepted beat not offered to back")

endmodule

`default_nettype wire

// File: src/pcim_back.sv
// Back end of the pixel color index mapper: two-stage datapath and the
// result queue. Depends on pcim_pkg.
`default_nettype none

module pcim_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire pcim_pkg::cmd_t   cmd_i,
  input  wire logic             cmd_valid_i,
  output logic                  cmd_ready_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output pcim_pkg::res_t        res_o
);

  logic             advance;

  // Stage 1.
  logic             s1_valid_q;
  pcim_pkg::op_e    s1_op_q;
  logic [4:0]       s1_bpc_q;
  logic [15:0]      s1_mask_q;
  logic [4:0]       s1_drop_q;
  logic [22:0]      s1_lum_sum_q;
  logic             s1_eq_q;
  logic [15:0]      s1_comp_a_q;
  logic [31:0]      s1_pack_q;
  logic [15:0]      s1_u0_q, s1_u1_q, s1_u2_q;
  logic [15:0]      s1_pr_q, s1_pg_q, s1_pb_q;

  logic [15:0]      mask_w;
  logic [4:0]       drop_w;
  logic [5:0]       sh2;
  logic [6:0]       sh3;
  logic [15:0]      sa, sb, sc, sd;
  logic [31:0]      rgb_pack, cmyk_pack, pack_w;
  logic [31:0]      u1_w, u2_w, u3_w;
  logic [15:0]      u0_s, u1_s, u2_s, u3_s;
  logic [31:0]      pr_w, pg_w, pb_w;
  logic [22:0]      lum_sum_w;

  // Stage 2.
  logic             s2_valid_q;
  pcim_pkg::op_e    s2_op_q;
  logic [4:0]       s2_bpc_q;
  logic [15:0]      s2_mask_q;
  logic [4:0]       s2_drop_q;
  logic [15:0]      s2_lum_q;
  logic             s2_eq_q;
  logic [15:0]      s2_comp_a_q;
  logic [31:0]      s2_pack_q;
  logic [15:0]      s2_xr_q, s2_xg_q, s2_xb_q;

  logic [46:0]      lum_prod;
  logic [15:0]      xr_w, xg_w, xb_w;

  // Final combine.
  logic [15:0]      qsc;
  logic [2:0]       rsc;
  logic [15:0]      sr, sg, sbl;
  logic [15:0]      gr_w;
  pcim_pkg::res_t   res_w;

  // Result queue.
  pcim_pkg::res_t   oq_mem_q [2];
  logic             oq_wr_q, oq_wr_d;
  logic             oq_rd_q, oq_rd_d;
  logic [1:0]       oq_cnt_q, oq_cnt_d;
  logic             oq_push;
  logic             oq_pop;

  assign oq_pop      = pop_i && !empty_o;
  assign advance     = (oq_cnt_q != 2'd2) || oq_pop;
  assign cmd_ready_o = advance;
  assign oq_push     = s2_valid_q && advance;

  function automatic logic [15:0] scale(input logic [15:0] x, input logic [15:0] q,
                                        input logic [2:0] r, input logic [4:0] bpc,
                                        input logic [15:0] mask);
    logic [31:0] prod;
    logic [23:0] y;
    logic [15:0] c;
    prod = {16'd0, x} * {16'd0, q};
    y    = ({8'd0, x} << r) - {8'd0, x};
    c    = pcim_pkg::div_mask(y, bpc, mask);
    return prod[15:0] + c;
  endfunction

  always_comb begin
    mask_w    = 16'(({1'b0, 16'd0} | 17'd1) << cmd_i.bpc) - 16'd1;
    drop_w    = 5'd16 - cmd_i.bpc;
    sh2       = {cmd_i.bpc, 1'b0};
    sh3       = {1'b0, sh2} + {2'b00, cmd_i.bpc};
    sa        = cmd_i.comp_a >> drop_w;
    sb        = cmd_i.comp_b >> drop_w;
    sc        = cmd_i.comp_c >> drop_w;
    sd        = cmd_i.comp_d >> drop_w;
    rgb_pack  = ({16'd0, sa} << sh2) | ({16'd0, sb} << cmd_i.bpc) | {16'd0, sc};
    cmyk_pack = ({16'd0, sa} << sh3) | ({16'd0, sb} << sh2) |
                ({16'd0, sc} << cmd_i.bpc) | {16'd0, sd};
    if (cmyk_pack == 32'hFFFF_FFFF) begin
      cmyk_pack = cmyk_pack ^ 32'd1;
    end
    pack_w    = (cmd_i.op == pcim_pkg::OP_RGB_FWD) ? rgb_pack : cmyk_pack;
    u1_w      = cmd_i.index >> cmd_i.bpc;
    u2_w      = cmd_i.index >> sh2;
    u3_w      = cmd_i.index >> sh3;
    u0_s      = cmd_i.index[15:0] & mask_w;
    u1_s      = u1_w[15:0] & mask_w;
    u2_s      = u2_w[15:0] & mask_w;
    u3_s      = u3_w[15:0] & mask_w;
    pr_w      = {16'd0, mask_w - u3_s} * {16'd0, mask_w - u0_s};
    pg_w      = {16'd0, mask_w - u2_s} * {16'd0, mask_w - u0_s};
    pb_w      = {16'd0, mask_w - u1_s} * {16'd0, mask_w - u0_s};
    lum_sum_w = 23'(cmd_i.comp_a) * 23'(pcim_pkg::LUM_R) +
                23'(cmd_i.comp_b) * 23'(pcim_pkg::LUM_G) +
                23'(cmd_i.comp_c) * 23'(pcim_pkg::LUM_B) + 23'(pcim_pkg::LUM_ROUND);
  end

  always_comb begin
    lum_prod = 47'(s1_lum_sum_q) * 47'(pcim_pkg::LUM_RECIP);
    unique case (s1_op_q)
      pcim_pkg::OP_RGB_INV: begin
        xr_w = s1_u2_q;
        xg_w = s1_u1_q;
        xb_w = s1_u0_q;
      end
      pcim_pkg::OP_CMYK_INV: begin
        xr_w = pcim_pkg::div_mask({8'd0, s1_pr_q}, s1_bpc_q, s1_mask_q);
        xg_w = pcim_pkg::div_mask({8'd0, s1_pg_q}, s1_bpc_q, s1_mask_q);
        xb_w = pcim_pkg::div_mask({8'd0, s1_pb_q}, s1_bpc_q, s1_mask_q);
      end
      default: begin
        xr_w = s1_u0_q;
        xg_w = s1_u0_q;
        xb_w = s1_u0_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= cmd_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_op_q      <= cmd_i.op;
      s1_bpc_q     <= cmd_i.bpc;
      s1_mask_q    <= mask_w;
      s1_drop_q    <= drop_w;
      s1_lum_sum_q <= lum_sum_w;
      s1_eq_q      <= (cmd_i.comp_a == cmd_i.comp_b) && (cmd_i.comp_b == cmd_i.comp_c);
      s1_comp_a_q  <= cmd_i.comp_a;
      s1_pack_q    <= pack_w;
      s1_u0_q      <= u0_s;
      s1_u1_q      <= u1_s;
      s1_u2_q      <= u2_s;
      s1_pr_q      <= pr_w[15:0];
      s1_pg_q      <= pg_w[15:0];
      s1_pb_q      <= pb_w[15:0];
      s2_op_q      <= s1_op_q;
      s2_bpc_q     <= s1_bpc_q;
      s2_mask_q    <= s1_mask_q;
      s2_drop_q    <= s1_drop_q;
      s2_lum_q     <= lum_prod[pcim_pkg::LUM_SHIFT +: 16];
      s2_eq_q      <= s1_eq_q;
      s2_comp_a_q  <= s1_comp_a_q;
      s2_pack_q    <= s1_pack_q;
      s2_xr_q      <= xr_w;
      s2_xg_q      <= xg_w;
      s2_xb_q      <= xb_w;
    end
  end

  always_comb begin
    qsc   = pcim_pkg::scale_quot(s2_bpc_q);
    rsc   = pcim_pkg::scale_rem_bits(s2_bpc_q);
    sr    = scale(s2_xr_q, qsc, rsc, s2_bpc_q, s2_mask_q);
    sg    = scale(s2_xg_q, qsc, rsc, s2_bpc_q, s2_mask_q);
    sbl   = scale(s2_xb_q, qsc, rsc, s2_bpc_q, s2_mask_q);
    gr_w  = s2_lum_q;
    res_w = '0;
    unique case (s2_op_q) inside
      pcim_pkg::OP_BAD: res_w.bad = 1'b1;
      pcim_pkg::OP_GRAY_FWD: begin
        if (s2_bpc_q == 5'd1) begin
          gr_w = pcim_pkg::CV_MAX - s2_lum_q;
        end
        res_w.index = {16'd0, gr_w >> s2_drop_q};
      end
      pcim_pkg::OP_KMONO_FWD: begin
        if (s2_eq_q) begin
          gr_w = s2_comp_a_q;
        end
        res_w.index = {16'd0, (pcim_pkg::CV_MAX - gr_w) >> s2_drop_q};
      end
      pcim_pkg::OP_RGB_FWD, pcim_pkg::OP_CMYK_FWD: res_w.index = s2_pack_q;
      pcim_pkg::OP_GRAY_INV: begin
        if (s2_bpc_q == 5'd1) begin
          res_w.red = (s2_xr_q != 16'd0) ? 16'd0 : pcim_pkg::CV_MAX;
        end else begin
          res_w.red = sr;
        end
        res_w.green = res_w.red;
        res_w.blue  = res_w.red;
      end
      default: begin
        res_w.red   = sr;
        res_w.green = sg;
        res_w.blue  = sbl;
      end
    endcase
  end

  assign empty_o = (oq_cnt_q == 2'd0);
  assign res_o   = oq_mem_q[oq_rd_q];

  always_comb begin
    oq_wr_d  = oq_push ? !oq_wr_q : oq_wr_q;
    oq_rd_d  = oq_pop ? !oq_rd_q : oq_rd_q;
    oq_cnt_d = oq_cnt_q;
    if (oq_push && !oq_pop) begin
      oq_cnt_d = oq_cnt_q + 2'd1;
    end else if (!oq_push && oq_pop) begin
      oq_cnt_d = oq_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      oq_wr_q  <= oq_wr_d;
      oq_rd_q  <= oq_rd_d;
      oq_cnt_q <= oq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_mem_q[oq_wr_q] <= res_w;
    end
  end

`include "pixel_color_index_mapper_unit_assert.svh"

`PCIM_ASSERT_NEXT(a_push_lands, oq_push, oq_cnt_q != 2'd0, "result beat lost")
`PCIM_ASSERT_NEXT(a_hold_pipe, !advance, $stable(s2_valid_q) && $stable(s1_valid_q), "pipe moved")
`PCIM_ASSERT_NOW(a_bad_zero, !empty_o && res_o.bad, (res_o >> 1) == '0, "bad beat has data")

endmodule

`default_nettype wire

// File: src/pixel_color_index_mapper_unit.sv
// Top level of the pixel color index mapper unit.
// Instantiates pcim_front and pcim_back; depends on pcim_pkg.
//
// Usage:
//   Requests enter on push/full: a beat is taken at a clock edge with push
//   high and full low. Results leave on empty/pop: the oldest result sits
//   on the result ports while empty is low and is taken with pop high.
//   Config registers (0 color_model, 1 pixel_depth) are written through
//   cfg_we_i/cfg_idx_i/cfg_data_i; write them only while the unit is idle.
//   Every request yields exactly one result, in order; bad_request_o flags
//   a request that the current model and depth cannot serve.
//   Throughput: one request per cycle while the result queue is not
//   held full, bounded by the two-stage datapath (one multiplier level
//   per stage) and the two-entry queues.
//   Reset: color_model returns to gray, pixel_depth to 1, queues empty.
//   Stall: when pop stays low the result queue fills, the datapath holds,
//   then the command queue fills and full rises.
`default_nettype none

module pixel_color_index_mapper_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [5:0]  cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [15:0] comp_a_i,
  input  wire logic [15:0] comp_b_i,
  input  wire logic [15:0] comp_c_i,
  input  wire logic [15:0] comp_d_i,
  input  wire logic [31:0] index_in_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      index_out_o,
  output logic [15:0]      red_out_o,
  output logic [15:0]      green_out_o,
  output logic [15:0]      blue_out_o,
  output logic             bad_request_o
);

  pcim_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_ready;
  pcim_pkg::res_t res;

  pcim_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .full_o      (full),
    .req_type_i  (req_type_i),
    .comp_a_i    (comp_a_i),
    .comp_b_i    (comp_b_i),
    .comp_c_i    (comp_c_i),
    .comp_d_i    (comp_d_i),
    .index_in_i  (index_in_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  pcim_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign index_out_o   = res.index;
  assign red_out_o     = res.red;
  assign green_out_o   = res.green;
  assign blue_out_o    = res.blue;
  assign bad_request_o = res.bad;

endmodule

`default_nettype wire
